### rtl/prmb_pkg.sv
// Package for the peak/RMS level meter: payload structs, the block record,
// configuration indexes, the back-end state type and fixed arithmetic constants.
// Depends on nothing.
`default_nettype none

package prmb_pkg;

  // Sample and accumulator widths.
  localparam int SAMPLE_BITS = 24;
  localparam int MAG_W       = SAMPLE_BITS - 1;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int SUM_W       = 59;
  localparam int CNT_W       = 17;
  localparam int LOG_W       = 22;

  // Offsets of the log domain, in Q.16.
  localparam logic signed [25:0] LOG_PEAK_OFS = 26'((SAMPLE_BITS - 1) * 65536);
  localparam logic signed [25:0] LOG_RMS_OFS  = 26'(2 * (SAMPLE_BITS - 1) * 65536);

  // 10*log10(2)/256 scaled by 2^32.
  localparam logic signed [26:0] DB_PER_LOG = 27'sd50504453;

  // Reset values of the configuration registers.
  localparam logic [15:0]        ATTACK_RST  = 16'd12378;
  localparam logic [15:0]        RELEASE_RST = 16'd61995;
  localparam logic signed [15:0] FLOOR_RST   = -16'sd15360;
  localparam logic signed [15:0] CEIL_RST    = 16'sd1536;

  typedef enum logic [2:0] {
    CFG_ATTACK  = 3'd0,
    CFG_RELEASE = 3'd1,
    CFG_FLOOR   = 3'd2,
    CFG_CEILING = 3'd3,
    CFG_MONO    = 3'd4
  } prmb_cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          block_last;
  } prmb_in_t;

  typedef struct packed {
    logic signed [15:0] peak_left_db;
    logic signed [15:0] peak_right_db;
    logic signed [15:0] rms_left_db;
    logic signed [15:0] rms_right_db;
    logic signed [15:0] raw_peak_left_db;
    logic signed [15:0] raw_peak_right_db;
    logic signed [15:0] raw_rms_left_db;
    logic signed [15:0] raw_rms_right_db;
  } prmb_out_t;

  typedef struct packed {
    logic [15:0]        attack_coef;
    logic [15:0]        release_coef;
    logic signed [15:0] floor_db;
    logic signed [15:0] ceiling_db;
    logic               mono_mode;
  } prmb_cfg_t;

  // One closed metering block, handed from the front end to the back end.
  typedef struct packed {
    logic [MAG_W-1:0] peak_l;
    logic [MAG_W-1:0] peak_r;
    logic [SUM_W-1:0] sum_l;
    logic [SUM_W-1:0] sum_r;
    logic [CNT_W-1:0] count;
    logic             mono;
  } prmb_blk_t;

  typedef struct packed {
    logic       empty;
    logic [1:0] count;
  } prmb_qstat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_DB_MUL,
    ST_DB_CLAMP,
    ST_SM_MUL,
    ST_SM_ADD,
    ST_DONE
  } prmb_state_t;

endpackage

`default_nettype wire

### rtl/prmb_front.sv
// Front end of the level meter: magnitude, square and per-block accumulation.
// Uses prmb_pkg; pushes one prmb_blk_t record per closed block.
`default_nettype none

module prmb_front
  import prmb_pkg::*;
#(
  parameter int MAX_BLOCK_FRAMES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire prmb_in_t    in_data,
  input  wire logic        mono_mode,
  input  wire prmb_qstat_t q_stat,
  output logic             q_push,
  output prmb_blk_t        q_data
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK_FRAMES);

  logic             v1_r, last1_r, v2_r, last2_r;
  logic [MAG_W-1:0] magl1_r, magr1_r, magl2_r, magr2_r;
  logic [SQ_W-1:0]  sql2_r, sqr2_r;
  logic [MAG_W-1:0] peakl_r, peakr_r, peakl_nxt, peakr_nxt;
  logic [SUM_W-1:0] suml_r, sumr_r, suml_nxt, sumr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W:0]   addl, addr;
  logic [2:0]       reserved;
  logic             accept;

  // Saturating magnitude of a signed sample.
  function automatic logic [MAG_W-1:0] mag_of(input logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] neg;
    neg = SAMPLE_BITS'(~s + 1'b1);
    if (!s[SAMPLE_BITS-1]) begin
      return s[MAG_W-1:0];
    end else if (neg[SAMPLE_BITS-1]) begin
      return {MAG_W{1'b1}};
    end else begin
      return neg[MAG_W-1:0];
    end
  endfunction

  // Queue space is reserved for every last beat still in the pipeline.
  assign reserved = {1'b0, q_stat.count} + {2'b0, v1_r & last1_r} + {2'b0, v2_r & last2_r};
  assign in_full  = (reserved >= 3'd2);
  assign accept   = in_push && !in_full;

  // Stage one: magnitudes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      last1_r <= 1'b0;
    end else begin
      v1_r    <= accept;
      last1_r <= in_data.block_last;
    end
    magl1_r <= mag_of(in_data.left_sample);
    magr1_r <= mag_of(in_data.right_sample);
  end

  // Stage two: squares.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      last2_r <= 1'b0;
    end else begin
      v2_r    <= v1_r;
      last2_r <= last1_r;
    end
    magl2_r <= magl1_r;
    magr2_r <= magr1_r;
    sql2_r  <= magl1_r * magl1_r;
    sqr2_r  <= magr1_r * magr1_r;
  end

  // Stage three: running peak, saturating sum and frame count.
  always_comb begin
    addl      = {1'b0, suml_r} + (SUM_W + 1)'(sql2_r);
    addr      = {1'b0, sumr_r} + (SUM_W + 1)'(sqr2_r);
    peakl_nxt = (magl2_r > peakl_r) ? magl2_r : peakl_r;
    peakr_nxt = (magr2_r > peakr_r) ? magr2_r : peakr_r;
    suml_nxt  = addl[SUM_W] ? {SUM_W{1'b1}} : addl[SUM_W-1:0];
    sumr_nxt  = addr[SUM_W] ? {SUM_W{1'b1}} : addr[SUM_W-1:0];
    cnt_nxt   = (cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peakl_r <= '0;
      peakr_r <= '0;
      suml_r  <= '0;
      sumr_r  <= '0;
      cnt_r   <= '0;
    end else if (v2_r) begin
      if (last2_r) begin
        peakl_r <= '0;
        peakr_r <= '0;
        suml_r  <= '0;
        sumr_r  <= '0;
        cnt_r   <= '0;
      end else begin
        peakl_r <= peakl_nxt;
        peakr_r <= peakr_nxt;
        suml_r  <= suml_nxt;
        sumr_r  <= sumr_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // The closing beat hands the finished block to the queue.
  assign q_push        = v2_r && last2_r;
  assign q_data.peak_l = peakl_nxt;
  assign q_data.peak_r = peakr_nxt;
  assign q_data.sum_l  = suml_nxt;
  assign q_data.sum_r  = sumr_nxt;
  assign q_data.count  = cnt_nxt;
  assign q_data.mono   = mono_mode;

endmodule

`default_nettype wire

### rtl/prmb_queue.sv
// Two-entry queue of closed block records between front and back end.
// Uses prmb_pkg for the record and status types.
`default_nettype none

module prmb_queue
  import prmb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire prmb_blk_t wdata,
  input  wire logic      pop,
  output prmb_blk_t      rdata,
  output prmb_qstat_t    stat
);

  prmb_blk_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign rdata      = mem_r[rp_r];
  assign stat.empty = (cnt_r == 2'd0);
  assign stat.count = cnt_r;

endmodule

`default_nettype wire

### rtl/prmb_back.sv
// Back end of the level meter: log2 by repeated squaring, dB conversion,
// clamping and attack/release smoothing, with a one-beat result register.
// Uses prmb_pkg.
`default_nettype none

module prmb_back
  import prmb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire prmb_cfg_t   cfg,
  input  wire prmb_blk_t   q_data,
  input  wire prmb_qstat_t q_stat,
  output logic             q_pop,
  output logic             out_empty,
  input  wire logic        out_pop,
  output prmb_out_t        out_data
);

  prmb_state_t state_r, state_nxt;
  prmb_blk_t   blk_r;

  logic [63:0]        x_r;
  logic [5:0]         e_r;
  logic [31:0]        m_r;
  logic [63:0]        sq_r;
  logic [15:0]        frac_r;
  logic [3:0]         it_r;
  logic [2:0]         op_r;
  logic [1:0]         lv_r;
  logic [LOG_W-1:0]   log_r [5];
  logic signed [52:0] dbp_r;
  logic signed [33:0] smp_r;
  logic signed [15:0] raw_r [4];
  logic signed [15:0] sm_r  [4];
  logic               out_valid_r;
  prmb_out_t          out_r;
  logic               out_load;

  logic [32:0]        sq_t;
  logic [15:0]        frac_nxt;
  logic signed [25:0] p;
  logic signed [52:0] db_rnd;
  logic signed [20:0] d, fl21, ce21;
  logic               is_zero;
  logic signed [15:0] clamped, target, held;
  logic signed [16:0] diff;
  logic signed [33:0] sm_rnd;

  // Value whose log2 the operand index selects.
  function automatic logic [63:0] op_value(input prmb_blk_t b, input logic [2:0] op);
    case (op)
      3'd0:    return 64'(b.peak_l);
      3'd1:    return 64'(b.peak_r);
      3'd2:    return 64'(b.sum_l);
      3'd3:    return 64'(b.sum_r);
      default: return 64'(b.count);
    endcase
  endfunction

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (!q_stat.empty) state_nxt = ST_NORM;
      ST_NORM:     if (x_r[63] || e_r == 6'd0) state_nxt = ST_SQ_MUL;
      ST_SQ_MUL:   state_nxt = ST_SQ_ACC;
      ST_SQ_ACC: begin
        if (it_r == 4'd15) begin
          state_nxt = (op_r == 3'd4) ? ST_DB_MUL : ST_NORM;
        end else begin
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_DB_MUL:   state_nxt = ST_DB_CLAMP;
      ST_DB_CLAMP: state_nxt = (lv_r == 2'd3) ? ST_SM_MUL : ST_DB_MUL;
      ST_SM_MUL:   state_nxt = ST_SM_ADD;
      ST_SM_ADD:   state_nxt = (lv_r == 2'd3) ? ST_DONE : ST_SM_MUL;
      ST_DONE:     if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Control strobes.
  always_comb begin
    q_pop    = (state_r == ST_IDLE) && !q_stat.empty;
    out_load = (state_r == ST_DONE) && (!out_valid_r || out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Squaring step of the log2 fraction.
  always_comb begin
    sq_t     = sq_r[63:31];
    frac_nxt = {frac_r[14:0], sq_t[32]};
  end

  // Power in the log domain for the current level.
  always_comb begin
    case (lv_r)
      2'd0:    p = ($signed({4'b0, log_r[0]}) - LOG_PEAK_OFS) <<< 1;
      2'd1:    p = ($signed({4'b0, log_r[1]}) - LOG_PEAK_OFS) <<< 1;
      2'd2:    p = $signed({4'b0, log_r[2]}) - $signed({4'b0, log_r[4]}) - LOG_RMS_OFS;
      default: p = $signed({4'b0, log_r[3]}) - $signed({4'b0, log_r[4]}) - LOG_RMS_OFS;
    endcase
  end

  // Rounding, zero check and clamp of the dB value.
  always_comb begin
    db_rnd = dbp_r + 53'sh80000000;
    d      = db_rnd[52:32];
    fl21   = 21'(cfg.floor_db);
    ce21   = 21'(cfg.ceiling_db);
    case (lv_r)
      2'd0:    is_zero = (blk_r.peak_l == '0);
      2'd1:    is_zero = (blk_r.peak_r == '0);
      2'd2:    is_zero = (blk_r.sum_l == '0);
      default: is_zero = (blk_r.sum_r == '0);
    endcase
    if (is_zero || d < fl21) begin
      clamped = cfg.floor_db;
    end else if (d > ce21) begin
      clamped = cfg.ceiling_db;
    end else begin
      clamped = d[15:0];
    end
  end

  // Smoothing operands and rounding.
  always_comb begin
    target = raw_r[lv_r];
    held   = sm_r[lv_r];
    diff   = 17'(held) - 17'(target);
    sm_rnd = smp_r + 34'sd32768;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        sm_r[i] <= FLOOR_RST;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          blk_r  <= q_data;
          x_r    <= op_value(q_data, 3'd0);
          e_r    <= 6'd63;
          frac_r <= '0;
          it_r   <= '0;
          op_r   <= '0;
        end
        ST_NORM: begin
          if (x_r[63] || e_r == 6'd0) begin
            m_r <= x_r[63:32];
          end else begin
            x_r <= {x_r[62:0], 1'b0};
            e_r <= e_r - 1'b1;
          end
        end
        ST_SQ_MUL: sq_r <= m_r * m_r;
        ST_SQ_ACC: begin
          frac_r <= frac_nxt;
          m_r    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
          it_r   <= it_r + 1'b1;
          if (it_r == 4'd15) begin
            log_r[op_r] <= {e_r, frac_nxt};
            op_r   <= op_r + 1'b1;
            x_r    <= op_value(blk_r, op_r + 1'b1);
            e_r    <= 6'd63;
            frac_r <= '0;
            lv_r   <= '0;
          end
        end
        ST_DB_MUL: dbp_r <= p * DB_PER_LOG;
        ST_DB_CLAMP: begin
          if (blk_r.mono && lv_r[0]) begin
            raw_r[lv_r] <= raw_r[lv_r - 1'b1];
          end else begin
            raw_r[lv_r] <= clamped;
          end
          lv_r <= lv_r + 1'b1;
        end
        ST_SM_MUL: begin
          if (target > held) begin
            smp_r <= $signed({1'b0, cfg.attack_coef}) * diff;
          end else begin
            smp_r <= $signed({1'b0, cfg.release_coef}) * diff;
          end
        end
        ST_SM_ADD: begin
          sm_r[lv_r] <= target + sm_rnd[31:16];
          lv_r       <= lv_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result register: one beat waits here while the next block is worked on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_r.peak_left_db      <= sm_r[0];
      out_r.peak_right_db     <= sm_r[1];
      out_r.rms_left_db       <= sm_r[2];
      out_r.rms_right_db      <= sm_r[3];
      out_r.raw_peak_left_db  <= raw_r[0];
      out_r.raw_peak_right_db <= raw_r[1];
      out_r.raw_rms_left_db   <= raw_r[2];
      out_r.raw_rms_right_db  <= raw_r[3];
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### rtl/peak_rms_meter_ballistics.sv
// Stereo peak/RMS level meter with attack/release ballistics, top level.
// Frames are accepted one per cycle while in_full is low; accumulation runs in a three-stage
// pipeline. A frame with block_last closes the block, and the block's record goes to a
// two-entry queue; the back end then takes log2 of five values by repeated squaring
// through one shared 32x32 multiplier, then does dB conversion, clamping and smoothing.
// in_full rises only while closed blocks waiting in the queue plus last frames still in
// the pipeline reach two, so input stalls only when closed blocks back up behind the
// back end, as when results are not taken.
// Depends on prmb_pkg, prmb_front, prmb_queue and prmb_back.
`default_nettype none

module peak_rms_meter_ballistics
  import prmb_pkg::*;
#(
  parameter int MAX_BLOCK_FRAMES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire prmb_in_t    in_data,
  input  wire logic        out_pop,
  output logic             out_empty,
  output prmb_out_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  prmb_cfg_t   cfg_r;
  prmb_blk_t   qw, qr;
  prmb_qstat_t qs;
  logic        q_push, q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_coef  <= ATTACK_RST;
      cfg_r.release_coef <= RELEASE_RST;
      cfg_r.floor_db     <= FLOOR_RST;
      cfg_r.ceiling_db   <= CEIL_RST;
      cfg_r.mono_mode    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ATTACK:  cfg_r.attack_coef  <= cfg_wdata;
        CFG_RELEASE: cfg_r.release_coef <= cfg_wdata;
        CFG_FLOOR:   cfg_r.floor_db     <= cfg_wdata;
        CFG_CEILING: cfg_r.ceiling_db   <= cfg_wdata;
        CFG_MONO:    cfg_r.mono_mode    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  prmb_front #(
    .MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .mono_mode(cfg_r.mono_mode),
    .q_stat   (qs),
    .q_push   (q_push),
    .q_data   (qw)
  );

  prmb_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(qw),
    .pop  (q_pop),
    .rdata(qr),
    .stat (qs)
  );

  prmb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_data   (qr),
    .q_stat   (qs),
    .q_pop    (q_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### rtl/prmb_checker.sv
// Port-level checks of the level meter and the bind that attaches them.
// Uses prmb_pkg for the result type.
`default_nettype none

module prmb_checker
  import prmb_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_full,
  input wire logic      out_empty,
  input wire logic      out_pop,
  input wire prmb_out_t out_data
);

  // Reset leaves no result waiting.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // Reset leaves room for input.
  a_rst_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input blocked right after reset");

  // A waiting result beat holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

endmodule

bind peak_rms_meter_ballistics prmb_checker u_prmb_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_full  (in_full),
  .out_empty(out_empty),
  .out_pop  (out_pop),
  .out_data (out_data)
);

`default_nettype wire

### bench/peak_rms_meter_ballistics_chk.sv
`timescale 1ns / 1ps
// Checker for the peak/RMS level meter: watches the frame, result and register ports,
// keeps its own model of the meter's levels and compares every result beat.
// Depends on prmb_pkg.
module peak_rms_meter_ballistics_chk
  import prmb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic          in_full,
  input  prmb_in_t      in_data,
  input  logic          out_pop,
  input  logic          out_empty,
  input  prmb_out_t     out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [15:0]   cfg_wdata,
  output int            pending_levels,
  output int            fail_count
);

  localparam longint unsigned SUM_LIMIT = (64'd1 << 59) - 64'd1;
  localparam int FRAME_LIMIT = 4096;
  localparam longint DB_SCALE = 64'sd50504453;

  // Register copies.
  logic [15:0] attack_q, release_q;
  int floor_q, ceiling_q;
  logic mono_q;

  // Block accumulators and held levels (peak L, peak R, rms L, rms R).
  longint unsigned peak_mag [2];
  longint unsigned sq_sum [2];
  int frames;
  int held_db [4];

  prmb_out_t level_q [$];
  int mismatches;

  string field_name [8] = '{"peak_left_db", "peak_right_db", "rms_left_db",
    "rms_right_db", "raw_peak_left_db", "raw_peak_right_db", "raw_rms_left_db",
    "raw_rms_right_db"};

  // Integer log2 in Q.16, fraction by repeated squaring with truncation.
  function automatic longint log2_fix(longint unsigned x);
    int e;
    longint unsigned m;
    longint frac;
    e = 63;
    frac = 0;
    while (e > 0 && x[e] == 1'b0) e--;
    if (e >= 31) m = x >> (e - 31);
    else m = x << (31 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (longint'(e) << 16) | frac;
  endfunction

  // Power log (Q.16) to clamped dB Q8.8; the floor test wins over the ceiling.
  function automatic int log_to_db(longint p);
    longint d;
    d = (p * DB_SCALE + (64'sd1 <<< 31)) >>> 32;
    if (d < floor_q) return floor_q;
    if (d > ceiling_q) return ceiling_q;
    return int'(d);
  endfunction

  function automatic int peak_level(longint unsigned mag);
    if (mag == 0) return floor_q;
    return log_to_db(2 * (log2_fix(mag) - (longint'(SAMPLE_BITS - 1) << 16)));
  endfunction

  function automatic int rms_level(longint unsigned sum, int cnt);
    if (sum == 0 || cnt == 0) return floor_q;
    return log_to_db(log2_fix(sum) - log2_fix(longint'(cnt)) -
                     (longint'(2 * (SAMPLE_BITS - 1)) << 16));
  endfunction

  // One-pole ballistics: attack when the new level is above the held one.
  function automatic int ballistic(int held, int target);
    longint c, p;
    c = (target > held) ? longint'(attack_q) : longint'(release_q);
    p = c * longint'(held - target) + 32768;
    return target + int'(p >>> 16);
  endfunction

  function automatic longint unsigned magnitude(logic signed [SAMPLE_BITS-1:0] s);
    longint v;
    v = longint'(s);
    if (v < 0) v = -v;
    if (v > (64'sd1 <<< (SAMPLE_BITS - 1)) - 1) v = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    return longint'(v);
  endfunction

  task automatic take_sample(int ch, logic signed [SAMPLE_BITS-1:0] s);
    longint unsigned mag, sq;
    mag = magnitude(s);
    if (mag > peak_mag[ch]) peak_mag[ch] = mag;
    sq = mag * mag;
    if (sq > SUM_LIMIT - sq_sum[ch]) sq_sum[ch] = SUM_LIMIT;
    else sq_sum[ch] = sq_sum[ch] + sq;
  endtask

  // Accumulate one frame; a last frame closes the block and queues its levels.
  task automatic meter_frame(prmb_in_t f);
    int raw [4];
    prmb_out_t lv;
    take_sample(0, f.left_sample);
    take_sample(1, f.right_sample);
    if (frames < FRAME_LIMIT) frames++;
    if (f.block_last) begin
      raw[0] = peak_level(peak_mag[0]);
      raw[2] = rms_level(sq_sum[0], frames);
      if (mono_q) begin
        raw[1] = raw[0];
        raw[3] = raw[2];
      end else begin
        raw[1] = peak_level(peak_mag[1]);
        raw[3] = rms_level(sq_sum[1], frames);
      end
      for (int i = 0; i < 4; i++) held_db[i] = ballistic(held_db[i], raw[i]);
      lv.peak_left_db      = 16'(held_db[0]);
      lv.peak_right_db     = 16'(held_db[1]);
      lv.rms_left_db       = 16'(held_db[2]);
      lv.rms_right_db      = 16'(held_db[3]);
      lv.raw_peak_left_db  = 16'(raw[0]);
      lv.raw_peak_right_db = 16'(raw[1]);
      lv.raw_rms_left_db   = 16'(raw[2]);
      lv.raw_rms_right_db  = 16'(raw[3]);
      level_q.push_back(lv);
      peak_mag = '{0, 0};
      sq_sum = '{0, 0};
      frames = 0;
    end
  endtask

  // Compare one result beat with the oldest expected levels, field by field.
  task automatic check_levels(prmb_out_t got);
    prmb_out_t exp_lv;
    logic [15:0] ev [8];
    logic [15:0] gv [8];
    if (level_q.size() == 0) begin
      fail_count++;
      if (mismatches++ < 10) $display("unexpected result beat %h", got);
      return;
    end
    exp_lv = level_q.pop_front();
    {ev[0], ev[1], ev[2], ev[3], ev[4], ev[5], ev[6], ev[7]} = exp_lv;
    {gv[0], gv[1], gv[2], gv[3], gv[4], gv[5], gv[6], gv[7]} = got;
    for (int i = 0; i < 8; i++) begin
      if (gv[i] !== ev[i]) begin
        fail_count++;
        if (mismatches++ < 10)
          $display("%s mismatch: expected %0d, got %0d", field_name[i],
                   $signed(ev[i]), $signed(gv[i]));
      end
    end
  endtask

  assign pending_levels = level_q.size();

  // Sample all channels at the clock edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      attack_q   <= ATTACK_RST;
      release_q  <= RELEASE_RST;
      floor_q    <= FLOOR_RST;
      ceiling_q  <= CEIL_RST;
      mono_q     <= 1'b0;
      peak_mag   = '{0, 0};
      sq_sum     = '{0, 0};
      frames     = 0;
      held_db    = '{-15360, -15360, -15360, -15360};
      fail_count = 0;
      mismatches = 0;
    end else begin
      if (in_push && !in_full) meter_frame(in_data);
      if (out_pop && !out_empty) check_levels(out_data);
      if (cfg_we) begin
        case (prmb_cfg_idx_t'(cfg_addr))
          CFG_ATTACK:  attack_q  <= cfg_wdata;
          CFG_RELEASE: release_q <= cfg_wdata;
          CFG_FLOOR:   floor_q   <= int'($signed(cfg_wdata));
          CFG_CEILING: ceiling_q <= int'($signed(cfg_wdata));
          CFG_MONO:    mono_q    <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

### bench/peak_rms_meter_ballistics_tb.sv
`timescale 1ns / 1ps
// Testbench top for the peak/RMS level meter: clock, reset, frame and register stimulus,
// result draining with stalls, and the verdict. Depends on prmb_pkg, the meter RTL and
// peak_rms_meter_ballistics_chk.
module peak_rms_meter_ballistics_tb;
  import prmb_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT = 700;

  logic clk, rst_n;
  logic in_push, in_full;
  prmb_in_t in_data;
  logic out_pop, out_empty;
  prmb_out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_addr;
  logic [15:0] cfg_wdata;
  int pending_levels, fail_count;
  logic hold_off, stress_go;
  int cycles;
  int frames_sent;

  peak_rms_meter_ballistics i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_pop(out_pop), .out_empty(out_empty), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  peak_rms_meter_ballistics_chk i_chk (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_pop(out_pop), .out_empty(out_empty), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .pending_levels(pending_levels), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(5, 40);
    return $urandom_range(100, 300);
  endfunction

  // Sample values weighted toward extremes, zero and quiet levels.
  function automatic logic signed [23:0] pick_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 24'sh800000;
    if (r == 1) return 24'sh7fffff;
    if (r == 2) return 24'sd0;
    if (r < 6) return 24'($signed($urandom_range(0, 255)) - 128);
    return 24'($urandom);
  endfunction

  // Present one frame beat and hold it until accepted, then idle at random.
  task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r, logic last);
    int gap;
    in_push <= 1'b1;
    in_data <= '{left_sample: l, right_sample: r, block_last: last};
    do @(posedge clk); while (in_full);
    frames_sent++;
    gap = idle_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_block(int len);
    for (int i = 0; i < len; i++) send_frame(pick_sample(), pick_sample(), i == len - 1);
  endtask

  // Wait for every level to arrive, let the back end settle, then write all registers.
  task automatic set_regs(logic [15:0] att, logic [15:0] rel, logic [15:0] flo,
                          logic [15:0] ceil, logic mono);
    logic [15:0] vals [5];
    vals = '{att, rel, flo, ceil, {15'd0, mono}};
    in_push <= 1'b0;
    while (pending_levels != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n_frames);
    int len, r;
    int stop_at;
    stop_at = frames_sent + n_frames;
    while (frames_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 200);
      send_block(len);
    end
  endtask

  // Result side: runs of pops and stalls, with one long hold-off on request.
  initial begin
    int run;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      run = $urandom_range(1, 30);
      repeat (run) begin
        out_pop <= !hold_off;
        @(posedge clk);
      end
      run = idle_len();
      repeat (run) begin
        out_pop <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Long receiver hold-off while frames keep coming, so in_full must rise.
  initial begin
    hold_off = 1'b0;
    wait (stress_go);
    hold_off = 1'b1;
    repeat (4000) @(posedge clk);
    hold_off = 1'b0;
  end

  // Run limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    stress_go = 1'b0;
    frames_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full scale, most negative sample, silence, tiny levels, mixed blocks.
    send_frame(24'sh7fffff, 24'sh7fffff, 1'b1);
    send_frame(24'sh800000, 24'sd0, 1'b1);
    send_frame(24'sd0, 24'sd0, 1'b1);
    send_frame(24'sd1, -24'sd1, 1'b1);
    send_frame(24'sh800000, 24'sh7fffff, 1'b0);
    send_frame(24'sd0, 24'sd0, 1'b0);
    send_frame(24'sd100, -24'sd3000, 1'b1);
    send_frame(24'sd0, 24'sh123456, 1'b0);
    send_frame(24'sd0, -24'sh123456, 1'b1);
    set_regs(16'd0, 16'd65535, 16'h8000, 16'h7fff, 1'b0);
    send_frame(24'sh7fffff, 24'sd0, 1'b1);
    send_frame(24'sd1, 24'sh800000, 1'b1);
    send_frame(24'sd0, 24'sd0, 1'b1);
    // Floor above the ceiling.
    set_regs(16'd65535, 16'd0, 16'h0000, 16'h8000, 1'b0);
    send_frame(24'sd5, 24'sh7fffff, 1'b1);
    send_frame(24'sd0, 24'sd0, 1'b1);
    // Mono copies the left levels; right input differs.
    set_regs(16'd12378, 16'd61995, 16'hc400, 16'h0600, 1'b1);
    send_frame(24'sh400000, 24'sd7, 1'b1);
    send_frame(24'sd0, 24'sh7fffff, 1'b1);
    // Floor raised and mono off; the register writes do not move the held levels.
    set_regs(16'd12378, 16'd61995, 16'he000, 16'h0600, 1'b0);
    send_frame(24'sd0, 24'sd0, 1'b1);

    // Random phases over several register settings.
    set_regs(16'd12378, 16'd61995, 16'hc400, 16'h0600, 1'b0);
    stress_go = 1'b1;
    random_phase(450);
    set_regs(16'($urandom), 16'($urandom), 16'(-$urandom_range(0, 32768)),
             16'($urandom), 1'b1);
    random_phase(300);
    set_regs(16'd0, 16'd65535, 16'h8000, 16'h7fff, 1'b0);
    random_phase(250);
    set_regs(16'($urandom), 16'($urandom), 16'(-$urandom_range(0, 4000)),
             16'($urandom_range(0, 3000)), 1'b0);
    random_phase(450);

    // Long block at full scale: large square sums and a long frame count.
    set_regs(16'd12378, 16'd61995, 16'hc400, 16'h7fff, 1'b0);
    for (int i = 0; i < 200; i++)
      send_frame(24'sh800000, (i % 2) ? 24'sh7fffff : 24'sh400000, i == 199);

    in_push <= 1'b0;
    while (pending_levels != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
